>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Standalone header; expects a clock and an active-low reset argument.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SSID_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ssid assertion failed");

// expression must never be true outside reset
`define SSID_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ssid forbidden condition seen");

`endif

>>> hdl/ssid_pkg.sv
// Package for the sorted set store: operation and status codes, sequencer states.
// No dependencies.
`default_nettype none

package ssid_pkg;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ENTRY     = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_PUT,
        ST_LIST,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

>>> hdl/ssid_if.sv
// Valid/ready channel interfaces for the sorted set store.
// Request channel (mode, value) and result channel; widths from ssid_pkg.
`default_nettype none

interface ssid_in_if;
    logic                                valid;
    logic                                ready;
    logic [ssid_pkg::MODE_W-1:0]         mode;
    logic signed [ssid_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface ssid_out_if;
    logic                                valid;
    logic                                ready;
    logic [ssid_pkg::STATUS_W-1:0]       status;
    logic signed [ssid_pkg::VALUE_W-1:0] entry_value;
    logic                                list_empty;
    logic                                last;

    modport source (output valid, output status, output entry_value,
                    output list_empty, output last, input ready);
    modport sink   (input valid, input status, input entry_value,
                    input list_empty, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/sorted_set_insert_delete_core.sv
// Sorted set store; after a request is accepted the block is busy until its result, or
// its last list entry, is loaded; output stalls lengthen this. List streams one entry
// per cycle while the output is not stalled. One RAM entry is compared or moved per
// cycle, through one write and one read port. Ready only while idle: no new request is
// taken before the last is done; the result register lets the next one in while a
// result waits. Reset (sync, active low) empties the store by clearing the count only.
`default_nettype none

module sorted_set_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssid_in_if.sink    i_in,
    ssid_out_if.source o_out
);

    import ssid_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    t_state r_state, n_state;

    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_slot, n_slot;
    logic [CW-1:0]              r_count, n_count;
    logic [MODE_W-1:0]          r_op, n_op;
    logic signed [VALUE_W-1:0]  r_value, n_value;
    logic [STATUS_W-1:0]        r_status, n_status;

    logic                       r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]        r_out_status, n_out_status;
    logic signed [VALUE_W-1:0]  r_out_value, n_out_value;
    logic                       r_out_empty, n_out_empty;
    logic                       r_out_last, n_out_last;

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [VALUE_W-1:0]         w_wdata;
    logic [VALUE_W-1:0]         w_rdata;

    logic                       w_in_acc;
    logic                       w_free;
    logic                       w_load;
    logic                       w_at_end;
    logic                       w_less;
    logic                       w_stop;
    logic                       w_match;
    logic                       w_full;
    logic [CW-1:0]              w_cnt_m1;
    logic [CW-1:0]              w_idx_p1;
    logic [CW-1:0]              w_idx_m1;

    // read address follows the next index, so read data always shows entry r_idx
    ssid_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_free     = !r_out_valid || o_out.ready;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_idx_p1 = r_idx + CW'(1);
    assign w_idx_m1 = r_idx - CW'(1);
    assign w_at_end = (r_idx == r_count);
    assign w_less   = $signed(w_rdata) < r_value;
    assign w_stop   = w_at_end || !w_less;
    assign w_match  = !w_at_end && ($signed(w_rdata) == r_value);
    assign w_full   = (r_count == CW'(CAPACITY));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.mode inside {MODE_INSERT, MODE_DELETE}) begin
                        n_state = ST_SCAN;
                    end else if (i_in.mode == MODE_LIST) begin
                        n_state = ST_LIST;
                    end
                end
            end
            ST_SCAN: begin
                if (w_stop) begin
                    if (r_op == MODE_INSERT) begin
                        if (w_match || w_full) begin
                            n_state = ST_RESP;
                        end else if (w_at_end) begin
                            n_state = ST_PUT;
                        end else begin
                            n_state = ST_SHIFT_UP;
                        end
                    end else begin
                        if (w_match && (r_idx != w_cnt_m1)) begin
                            n_state = ST_SHIFT_DN;
                        end else begin
                            n_state = ST_RESP;
                        end
                    end
                end
            end
            ST_SHIFT_UP: begin
                if (r_idx == r_slot) begin
                    n_state = ST_PUT;
                end
            end
            ST_SHIFT_DN: begin
                if (r_idx == w_cnt_m1) begin
                    n_state = ST_RESP;
                end
            end
            ST_PUT: begin
                n_state = ST_RESP;
            end
            ST_LIST: begin
                if (w_free && ((r_count == '0) || (r_idx == w_cnt_m1))) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (w_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and result register loads
    always_comb begin
        n_idx        = r_idx;
        n_slot       = r_slot;
        n_count      = r_count;
        n_op         = r_op;
        n_value      = r_value;
        n_status     = r_status;
        w_we         = 1'b0;
        w_waddr      = r_idx[AW-1:0];
        w_wdata      = w_rdata;
        w_load       = 1'b0;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_empty  = r_out_empty;
        n_out_last   = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_op    = i_in.mode;
                    n_value = i_in.value;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                if (!w_stop) begin
                    n_idx = w_idx_p1;
                end else begin
                    n_slot = r_idx;
                    if (r_op == MODE_INSERT) begin
                        if (w_match) begin
                            n_status = STAT_DUPLICATE;
                        end else if (w_full) begin
                            n_status = STAT_FULL;
                        end else if (!w_at_end) begin
                            n_idx = w_cnt_m1;
                        end
                    end else begin
                        if (!w_match) begin
                            n_status = STAT_NOT_FOUND;
                        end else if (r_idx == w_cnt_m1) begin
                            n_count  = w_cnt_m1;
                            n_status = STAT_REMOVED;
                        end else begin
                            n_idx = w_idx_p1;
                        end
                    end
                end
            end
            ST_SHIFT_UP: begin
                // move entry r_idx one place up
                w_we    = 1'b1;
                w_waddr = w_idx_p1[AW-1:0];
                if (r_idx != r_slot) begin
                    n_idx = w_idx_m1;
                end
            end
            ST_SHIFT_DN: begin
                // move entry r_idx one place down
                w_we    = 1'b1;
                w_waddr = w_idx_m1[AW-1:0];
                if (r_idx == w_cnt_m1) begin
                    n_count  = w_cnt_m1;
                    n_status = STAT_REMOVED;
                end else begin
                    n_idx = w_idx_p1;
                end
            end
            ST_PUT: begin
                w_we     = 1'b1;
                w_waddr  = r_slot[AW-1:0];
                w_wdata  = r_value;
                n_count  = r_count + CW'(1);
                n_status = STAT_INSERTED;
            end
            ST_LIST: begin
                if (w_free) begin
                    w_load       = 1'b1;
                    n_out_status = STAT_ENTRY;
                    n_idx        = w_idx_p1;
                    if (r_count == '0) begin
                        n_out_value = '0;
                        n_out_empty = 1'b1;
                        n_out_last  = 1'b1;
                    end else begin
                        n_out_value = $signed(w_rdata);
                        n_out_empty = 1'b0;
                        n_out_last  = (r_idx == w_cnt_m1);
                    end
                end
            end
            ST_RESP: begin
                if (w_free) begin
                    w_load       = 1'b1;
                    n_out_status = r_status;
                    n_out_value  = r_value;
                    n_out_empty  = 1'b0;
                    n_out_last   = 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_op         <= n_op;
        r_value      <= n_value;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_empty  <= n_out_empty;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.entry_value = r_out_value;
    assign o_out.list_empty  = r_out_empty;
    assign o_out.last        = r_out_last;

endmodule

`default_nettype wire

>>> hdl/ssid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/ssid_checker.sv
// Port-level checker for the sorted set store, bound to the top level.
// Depends on ssid_pkg and assert_macros.svh.
`default_nettype none

module ssid_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [ssid_pkg::STATUS_W-1:0]       i_out_status,
    input wire logic signed [ssid_pkg::VALUE_W-1:0] i_out_value,
    input wire logic                                i_out_empty,
    input wire logic                                i_out_last
);

    import ssid_pkg::*;

    `include "assert_macros.svh"

    `SSID_ASSERT(a_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `SSID_ASSERT(a_stall_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_status) && $stable(i_out_value))
    `SSID_ASSERT(a_empty_shape, i_clk, i_rst_n, i_out_valid && i_out_empty |-> i_out_last && (i_out_status == STAT_ENTRY) && (i_out_value == '0))
    `SSID_ASSERT_NEVER(a_single_result, i_clk, i_rst_n, i_out_valid && !i_out_last && (i_out_status != STAT_ENTRY))

endmodule

bind sorted_set_insert_delete_core ssid_checker u_ssid_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_value  (o_out.entry_value),
    .i_out_empty  (o_out.list_empty),
    .i_out_last   (o_out.last)
);

`default_nettype wire

>>> sim/tb_sorted_set_insert_delete_core.sv
// Testbench for sorted_set_insert_delete_core: random insert/delete/list traffic
// checked against a shadow sorted set. Uses ssid_pkg and the ssid_in_if/ssid_out_if
// interfaces from the RTL.
module tb_sorted_set_insert_delete_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ssid_pkg::*;

    localparam int STORE_CAP    = 16;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 385;
    localparam int QUIET_TAIL   = 40;    // no idling once this few items remain
    localparam int DRAIN_CYCLES = 2 * STORE_CAP + 20;
    localparam int HOLD_AT      = 120;   // accepted requests before the long stall
    localparam int HOLD_CYCLES  = 80;

    // unused mode code, must be ignored by the block
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } t_store_req;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] entry_value;
        logic                      list_empty;
        logic                      last;
    } t_store_result;

    logic i_clk;
    logic i_rst_n;

    ssid_in_if  in_if();
    ssid_out_if out_if();

    sorted_set_insert_delete_core #(.CAPACITY(STORE_CAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_store_req                pending_reqs[$];
    t_store_result             expected_results[$];
    logic signed [VALUE_W-1:0] shadow_set[STORE_CAP];
    int                        shadow_count;
    logic signed [VALUE_W-1:0] value_pool[POOL_SIZE];

    int  n_offered;
    int  n_accepted;
    int  n_checked;
    int  err_count;
    int  status_seen[6];
    int  send_gap;
    int  recv_stall;
    bit  hold_long;

    // ---------------------------------------------------------------- predictor
    function automatic void push_result(logic [STATUS_W-1:0] status,
                                        logic signed [VALUE_W-1:0] v,
                                        logic empty, logic last);
        t_store_result r;
        r.status      = status;
        r.entry_value = v;
        r.list_empty  = empty;
        r.last        = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_outcome(logic [MODE_W-1:0] mode,
                                            logic signed [VALUE_W-1:0] value);
        int pos;
        bit hit;
        pos = 0;
        while (pos < shadow_count && shadow_set[pos] < value)
            pos++;
        hit = (pos < shadow_count) && (shadow_set[pos] == value);
        case (mode)
            MODE_INSERT: begin
                // duplicate wins over full
                if (hit) begin
                    push_result(STAT_DUPLICATE, value, 1'b0, 1'b1);
                end else if (shadow_count >= STORE_CAP) begin
                    push_result(STAT_FULL, value, 1'b0, 1'b1);
                end else begin
                    for (int k = shadow_count; k > pos; k--)
                        shadow_set[k] = shadow_set[k-1];
                    shadow_set[pos] = value;
                    shadow_count++;
                    push_result(STAT_INSERTED, value, 1'b0, 1'b1);
                end
            end
            MODE_DELETE: begin
                if (hit) begin
                    for (int k = pos; k + 1 < shadow_count; k++)
                        shadow_set[k] = shadow_set[k+1];
                    shadow_count--;
                    push_result(STAT_REMOVED, value, 1'b0, 1'b1);
                end else begin
                    push_result(STAT_NOT_FOUND, value, 1'b0, 1'b1);
                end
            end
            MODE_LIST: begin
                if (shadow_count == 0)
                    push_result(STAT_ENTRY, '0, 1'b1, 1'b1);
                for (int k = 0; k < shadow_count; k++)
                    push_result(STAT_ENTRY, shadow_set[k], 1'b0, k + 1 == shadow_count);
            end
            default: ;  // unused mode: no effect, no result
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers
    function automatic void queue_req(logic [MODE_W-1:0] mode,
                                      logic signed [VALUE_W-1:0] value);
        t_store_req r;
        r.mode  = mode;
        r.value = value;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return value_pool[$urandom_range(0, POOL_SIZE-1)];
        return $urandom;
    endfunction

    // ---------------------------------------------------------------- clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- driver
    always @(negedge i_clk) begin : drive_requests
        bit         hold;
        bit         quiet;
        t_store_req req;
        hold  = in_if.valid && (n_accepted != n_offered);
        quiet = pending_reqs.size() < QUIET_TAIL;
        if (i_rst_n && !hold) begin
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 6);
                in_if.valid <= 1'b0;
            end else begin
                req = pending_reqs.pop_front();
                in_if.valid <= 1'b1;
                in_if.mode  <= req.mode;
                in_if.value <= req.value;
                n_offered++;
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    always @(negedge i_clk) begin : drive_ready
        bit quiet;
        quiet = pending_reqs.size() < QUIET_TAIL;
        if (i_rst_n) begin
            if (hold_long) begin
                out_if.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                recv_stall = $urandom_range(0, 6);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // long output stall while requests keep coming, so the input backs up
    initial begin
        hold_long = 1'b0;
        while (n_accepted < HOLD_AT)
            @(posedge i_clk);
        hold_long = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_long = 1'b0;
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin : monitor
        t_store_result exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d value %0d",
                       out_if.status, out_if.entry_value);
                err_count++;
            end else begin
                exp_r = expected_results.pop_front();
                n_checked++;
                if (exp_r.status <= STAT_ENTRY)
                    status_seen[exp_r.status]++;
                if (out_if.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, out_if.status);
                    err_count++;
                end
                if (out_if.entry_value !== exp_r.entry_value) begin
                    $error("entry_value: expected %0d, got %0d",
                           exp_r.entry_value, out_if.entry_value);
                    err_count++;
                end
                if (out_if.list_empty !== exp_r.list_empty) begin
                    $error("list_empty: expected %0d, got %0d",
                           exp_r.list_empty, out_if.list_empty);
                    err_count++;
                end
                if (out_if.last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, out_if.last);
                    err_count++;
                end
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            n_accepted++;
            predict_outcome(in_if.mode, in_if.value);
        end
    end

    // ---------------------------------------------------------------- timeout
    initial begin
        #4ms;
        $display("tb_sorted_set_insert_delete_core: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence
    initial begin : main_seq
        int n_random;
        int bias;
        int pick;
        logic [MODE_W-1:0] mode;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.mode   = MODE_INSERT;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        shadow_count = 0;
        n_offered    = 0;
        n_accepted   = 0;
        n_checked    = 0;
        err_count    = 0;
        send_gap     = 0;
        recv_stall   = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (shadow_set[i]) shadow_set[i] = '0;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        // directed: empty store, extremes, duplicates, misses, fill to full
        queue_req(MODE_LIST, $urandom);
        queue_req(MODE_DELETE, 32'sd5);
        queue_req(MODE_INSERT, 32'sh7fff_ffff);
        queue_req(MODE_INSERT, 32'sh8000_0000);
        queue_req(MODE_INSERT, 32'sd0);
        queue_req(MODE_INSERT, -32'sd1);
        queue_req(MODE_INSERT, 32'sd1);
        queue_req(MODE_INSERT, 32'sd0);
        queue_req(MODE_LIST, 32'hffff_ffff);
        queue_req(MODE_DELETE, 32'sh8000_0000);
        queue_req(MODE_DELETE, 32'sd2);
        queue_req(MODE_UNUSED, 32'sd1);
        for (int i = 0; i < 12; i++)
            queue_req(MODE_INSERT, 32'sd100 * (i + 1) - 32'sd550);
        queue_req(MODE_INSERT, 32'sd12345);     // new value on a full store
        queue_req(MODE_INSERT, 32'sh7fff_ffff); // duplicate on a full store
        queue_req(MODE_LIST, 32'sd0);

        // random: segments biased toward filling, draining, or mixed
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            bias = (n_random / 25) % 3;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                mode = MODE_UNUSED;
            else if (pick < 15)
                mode = MODE_LIST;
            else if (pick < (bias == 0 ? 85 : (bias == 1 ? 35 : 57)))
                mode = MODE_INSERT;
            else
                mode = MODE_DELETE;
            queue_req(mode, (mode == MODE_INSERT || mode == MODE_DELETE) ?
                            pick_value() : $urandom);
            if (mode != MODE_UNUSED)
                n_random++;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || n_accepted != n_offered)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, %0d results checked (one long output stall)",
                 n_accepted, n_checked);
        $display("inserted %0d, duplicate %0d, removed %0d, not found %0d, full %0d, entries %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (err_count == 0 && expected_results.size() == 0)
            $display("tb_sorted_set_insert_delete_core: PASS");
        else
            $display("tb_sorted_set_insert_delete_core: FAIL");
        $finish;
    end

endmodule

>>> sorted_set_insert_delete_core.f
+incdir+hdl
hdl/ssid_pkg.sv
hdl/ssid_if.sv
hdl/ssid_ram.sv
hdl/sorted_set_insert_delete_core.sv
hdl/ssid_checker.sv
sim/tb_sorted_set_insert_delete_core.sv
